[hw/rtl/hashed_owner_slot_allocator_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the hashed owner slot allocator
// Clocked on clk_i and disabled while rst_ni is low; empty for synthesis.
// ---------------------------------------------------------------------------
`ifndef HASHED_OWNER_SLOT_ALLOCATOR_MACROS_SVH
`define HASHED_OWNER_SLOT_ALLOCATOR_MACROS_SVH

`ifndef SYNTHESIS
`define HOSA_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define HOSA_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define HOSA_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define HOSA_ASSERT(name, prop, msg)
`define HOSA_ASSERT_IMP(name, ante, cons, msg)
`define HOSA_ASSERT_NEXT(name, ante, cons, msg)
`endif

`endif

[hw/rtl/hosa_pkg.sv]
// ---------------------------------------------------------------------------
// hosa_pkg
// Sizes, codes, the home-slot hash and the slot store request type.
// ---------------------------------------------------------------------------
package hosa_pkg;

  localparam int HOME_SLOTS  = 64;
  localparam int POOL_SLOTS  = 64;
  localparam int TOTAL_SLOTS = HOME_SLOTS + POOL_SLOTS;

  localparam int OWNER_W    = 64;
  localparam int SLOT_W     = 7;
  localparam int STATUS_W   = 3;
  localparam int LINK_W     = $clog2(TOTAL_SLOTS + 1);
  localparam int POOL_CNT_W = $clog2(POOL_SLOTS + 1);
  localparam int STEP_W     = $clog2(TOTAL_SLOTS);

  localparam logic [OWNER_W-1:0] HASH_LIMIT   = 64'h1000;
  localparam int                 HASH_SHIFT_A = 4;
  localparam int                 HASH_SHIFT_B = 8;

  localparam logic OP_ACQUIRE = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STAT_HIT       = 3'd0,
    STAT_CLAIMED   = 3'd1,
    STAT_APPENDED  = 3'd2,
    STAT_POOL_FULL = 3'd3,
    STAT_RELEASED  = 3'd4,
    STAT_NOT_FOUND = 3'd5
  } status_e;

  // Read port plus one write port per memory.
  typedef struct packed {
    logic                rd_en;
    logic [SLOT_W-1:0]   rd_addr;
    logic                own_we;
    logic [SLOT_W-1:0]   own_addr;
    logic [OWNER_W-1:0]  own_wdata;
    logic                lnk_we;
    logic [SLOT_W-1:0]   lnk_addr;
    logic [LINK_W-1:0]   lnk_wdata;
  } mem_req_t;

  function automatic logic [SLOT_W-1:0] home_slot(input logic [OWNER_W-1:0] id);
    logic [OWNER_W-1:0] h;
    h = id;
    if (id > HASH_LIMIT) begin
      h = (id >> HASH_SHIFT_A) ^ (id >> HASH_SHIFT_B);
    end
    return SLOT_W'(h % OWNER_W'(HOME_SLOTS));
  endfunction

endpackage

[hw/rtl/hosa_req_if.sv]
// ---------------------------------------------------------------------------
// hosa_req_if
// Request channel: valid/ready with op and owner id.
// ---------------------------------------------------------------------------
interface hosa_req_if;
  logic                         valid;
  logic                         ready;
  logic                         op;
  logic [hosa_pkg::OWNER_W-1:0] owner_id;

  modport source (output valid, output op, output owner_id, input ready);
  modport sink   (input valid, input op, input owner_id, output ready);
endinterface

[hw/rtl/hosa_rsp_if.sv]
// ---------------------------------------------------------------------------
// hosa_rsp_if
// Response channel: valid/ready with slot index and status.
// ---------------------------------------------------------------------------
interface hosa_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [hosa_pkg::SLOT_W-1:0]   slot_index;
  logic [hosa_pkg::STATUS_W-1:0] status;

  modport source (output valid, output slot_index, output status, input ready);
  modport sink   (input valid, input slot_index, input status, output ready);
endinterface

[hw/rtl/hashed_owner_slot_allocator.sv]
// ---------------------------------------------------------------------------
// hashed_owner_slot_allocator
// Chained hash table that maps a 64-bit owner id to one of 128 slots.
// ---------------------------------------------------------------------------
// Each request word carries an op (acquire or release) and an owner id; each
// response word carries one slot index and a status (hit, claimed free,
// appended from pool, pool full, released, not found). The home slot is the
// id's low six bits, or for ids above 0x1000 the low six bits of
// (id>>4)^(id>>8); slots 0-63 are home slots and 64-127 form an overflow
// pool that is handed out in order and never returned. On acceptance the
// home slot is read; the walk then visits the slots of its chain and loads
// the response register once it is done and that register is free. The owner
// and link memories have a registered read, so the walk moves one link a cycle.
// A new request is taken in the cycle after the response is loaded, even if
// that response still waits for the sink. Reset leaves every slot free and
// unlinked at once through per-entry valid bits, so there is no clearing
// pass. Pool-full and not-found responses carry slot index 0.
// ---------------------------------------------------------------------------
module hashed_owner_slot_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  hosa_req_if.sink    req_i,
  hosa_rsp_if.source  rsp_o
);
  import hosa_pkg::*;

  // Request bus from the walker to the slot memories.
  mem_req_t           mem_req;
  logic [OWNER_W-1:0] own_rdata;
  logic [LINK_W-1:0]  lnk_rdata;

  // Walk the chain, decide and write back.
  hosa_walker u_walker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .rsp_o       (rsp_o),
    .mem_req_o   (mem_req),
    .own_rdata_i (own_rdata),
    .lnk_rdata_i (lnk_rdata)
  );

  // Hold owners and links.
  hosa_slot_store u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (mem_req),
    .own_rdata_o (own_rdata),
    .lnk_rdata_o (lnk_rdata)
  );

endmodule

[hw/rtl/hosa_slot_store.sv]
// ---------------------------------------------------------------------------
// hosa_slot_store
// Owner and link memories, registered read, per-entry valid bits so that
// an unwritten entry reads as free with a null link.
// ---------------------------------------------------------------------------
module hosa_slot_store (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  hosa_pkg::mem_req_t           req_i,
  output logic [hosa_pkg::OWNER_W-1:0] own_rdata_o,
  output logic [hosa_pkg::LINK_W-1:0]  lnk_rdata_o
);
  import hosa_pkg::*;

  logic [OWNER_W-1:0]     owner_mem [TOTAL_SLOTS];
  logic [LINK_W-1:0]      link_mem  [TOTAL_SLOTS];
  logic [TOTAL_SLOTS-1:0] own_vld_q, own_vld_d;
  logic [TOTAL_SLOTS-1:0] lnk_vld_q, lnk_vld_d;
  logic [OWNER_W-1:0]     own_rd_q;
  logic [LINK_W-1:0]      lnk_rd_q;
  logic                   own_rv_q, own_rv_d;
  logic                   lnk_rv_q, lnk_rv_d;

  always_ff @(posedge clk_i) begin
    if (req_i.own_we) begin
      owner_mem[req_i.own_addr] <= req_i.own_wdata;
    end
    if (req_i.lnk_we) begin
      link_mem[req_i.lnk_addr] <= req_i.lnk_wdata;
    end
    if (req_i.rd_en) begin
      own_rd_q <= owner_mem[req_i.rd_addr];
      lnk_rd_q <= link_mem[req_i.rd_addr];
    end
  end

  always_comb begin
    own_vld_d = own_vld_q;
    lnk_vld_d = lnk_vld_q;
    own_rv_d  = own_rv_q;
    lnk_rv_d  = lnk_rv_q;
    if (req_i.rd_en) begin
      own_rv_d = own_vld_q[req_i.rd_addr];
      lnk_rv_d = lnk_vld_q[req_i.rd_addr];
    end
    if (req_i.own_we) begin
      own_vld_d[req_i.own_addr] = 1'b1;
    end
    if (req_i.lnk_we) begin
      lnk_vld_d[req_i.lnk_addr] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_vld_q <= '0;
      lnk_vld_q <= '0;
      own_rv_q  <= 1'b0;
      lnk_rv_q  <= 1'b0;
    end else begin
      own_vld_q <= own_vld_d;
      lnk_vld_q <= lnk_vld_d;
      own_rv_q  <= own_rv_d;
      lnk_rv_q  <= lnk_rv_d;
    end
  end

  // Read a never-written entry as free and unlinked.
  assign own_rdata_o = own_rv_q ? own_rd_q : '0;
  assign lnk_rdata_o = lnk_rv_q ? lnk_rd_q : '0;

endmodule

[hw/rtl/hosa_walker.sv]
// ---------------------------------------------------------------------------
// hosa_walker
// Chain walk sequencer: hash, follow links one slot a cycle, decide and
// write back, hold the result in an output register.
// ---------------------------------------------------------------------------
`include "hashed_owner_slot_allocator_macros.svh"

module hosa_walker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  hosa_req_if.sink                     req_i,
  hosa_rsp_if.source                   rsp_o,
  output hosa_pkg::mem_req_t           mem_req_o,
  input  logic [hosa_pkg::OWNER_W-1:0] own_rdata_i,
  input  logic [hosa_pkg::LINK_W-1:0]  lnk_rdata_i
);
  import hosa_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_WALK = 1'b1;

  logic                  state_q, state_d;
  logic                  op_q, op_d;
  logic [OWNER_W-1:0]    id_q, id_d;
  logic [SLOT_W-1:0]     cur_q, cur_d;
  logic [STEP_W-1:0]     steps_q, steps_d;
  logic                  have_free_q, have_free_d;
  logic [SLOT_W-1:0]     free_slot_q, free_slot_d;
  logic [POOL_CNT_W-1:0] pool_used_q, pool_used_d;
  logic                  out_valid_q, out_valid_d;
  logic [SLOT_W-1:0]     out_slot_q, out_slot_d;
  status_e               out_status_q, out_status_d;

  logic                  accept;
  logic                  match, is_free, nxt_ok, go_on, done, can_finish;
  logic [SLOT_W-1:0]     nxt;
  logic [SLOT_W-1:0]     new_slot;

  assign req_i.ready      = (state_q == S_IDLE);
  assign accept           = req_i.valid && req_i.ready;
  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.slot_index = out_slot_q;
  assign rsp_o.status     = out_status_q;

  assign match      = (own_rdata_i == id_q);
  assign is_free    = (own_rdata_i == '0);
  assign nxt_ok     = (lnk_rdata_i != '0) && (lnk_rdata_i <= LINK_W'(TOTAL_SLOTS));
  assign nxt        = SLOT_W'(lnk_rdata_i - LINK_W'(1));
  assign go_on      = nxt_ok && (steps_q != STEP_W'(TOTAL_SLOTS - 1));
  assign done       = match || !go_on;
  assign can_finish = !out_valid_q || rsp_o.ready;
  assign new_slot   = SLOT_W'(HOME_SLOTS) + SLOT_W'(pool_used_q);

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    id_d         = id_q;
    cur_d        = cur_q;
    steps_d      = steps_q;
    have_free_d  = have_free_q;
    free_slot_d  = free_slot_q;
    pool_used_d  = pool_used_q;
    out_valid_d  = out_valid_q && !rsp_o.ready;
    out_slot_d   = out_slot_q;
    out_status_d = out_status_q;
    mem_req_o    = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          mem_req_o.rd_en   = 1'b1;
          mem_req_o.rd_addr = home_slot(req_i.owner_id);
          op_d        = req_i.op;
          id_d        = req_i.owner_id;
          cur_d       = home_slot(req_i.owner_id);
          steps_d     = '0;
          have_free_d = 1'b0;
          state_d     = S_WALK;
        end
      end
      S_WALK: begin
        if (!done) begin
          // Advance to the next slot of the chain.
          mem_req_o.rd_en   = 1'b1;
          mem_req_o.rd_addr = nxt;
          cur_d   = nxt;
          steps_d = steps_q + STEP_W'(1);
          if (op_q == OP_ACQUIRE && is_free && !have_free_q) begin
            have_free_d = 1'b1;
            free_slot_d = cur_q;
          end
        end else if (can_finish) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
          if (op_q == OP_RELEASE) begin
            if (match) begin
              mem_req_o.own_we    = 1'b1;
              mem_req_o.own_addr  = cur_q;
              mem_req_o.own_wdata = '0;
              out_slot_d   = cur_q;
              out_status_d = STAT_RELEASED;
            end else begin
              out_slot_d   = '0;
              out_status_d = STAT_NOT_FOUND;
            end
          end else if (match) begin
            out_slot_d   = cur_q;
            out_status_d = STAT_HIT;
          end else if (have_free_q || is_free) begin
            // Claim the first free slot met on the walk.
            mem_req_o.own_we    = 1'b1;
            mem_req_o.own_addr  = have_free_q ? free_slot_q : cur_q;
            mem_req_o.own_wdata = id_q;
            out_slot_d   = have_free_q ? free_slot_q : cur_q;
            out_status_d = STAT_CLAIMED;
          end else if (pool_used_q < POOL_CNT_W'(POOL_SLOTS)) begin
            // Append a fresh pool slot; its own link is still null.
            mem_req_o.own_we    = 1'b1;
            mem_req_o.own_addr  = new_slot;
            mem_req_o.own_wdata = id_q;
            mem_req_o.lnk_we    = 1'b1;
            mem_req_o.lnk_addr  = cur_q;
            mem_req_o.lnk_wdata = LINK_W'(new_slot) + LINK_W'(1);
            pool_used_d  = pool_used_q + POOL_CNT_W'(1);
            out_slot_d   = new_slot;
            out_status_d = STAT_APPENDED;
          end else begin
            out_slot_d   = '0;
            out_status_d = STAT_POOL_FULL;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      have_free_q <= 1'b0;
      pool_used_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      have_free_q <= have_free_d;
      pool_used_q <= pool_used_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    id_q         <= id_d;
    cur_q        <= cur_d;
    steps_q      <= steps_d;
    free_slot_q  <= free_slot_d;
    out_slot_q   <= out_slot_d;
    out_status_q <= out_status_d;
  end

  `HOSA_ASSERT(a_pool_bound, pool_used_q <= POOL_CNT_W'(POOL_SLOTS), "pool count overflow")
  `HOSA_ASSERT_IMP(a_link_with_owner, mem_req_o.lnk_we, mem_req_o.own_we && state_q == S_WALK, "link write without append")
  `HOSA_ASSERT_NEXT(a_append_count, mem_req_o.lnk_we, pool_used_q == $past(pool_used_q) + POOL_CNT_W'(1), "pool count not advanced")
  `HOSA_ASSERT_IMP(a_accept_reads, accept, mem_req_o.rd_en && !mem_req_o.own_we, "accept without home read")
  `HOSA_ASSERT_IMP(a_no_write_on_stall, state_q == S_WALK && done && !can_finish, !mem_req_o.own_we && !out_valid_d == !out_valid_q, "write while result blocked")

endmodule

[sim/tb.sv]
// ---------------------------------------------------------------------------
// tb: hashed owner slot allocator
// Drives acquire and release words into the allocator and checks every
// response word against a cycle-free model of the slot table.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import hosa_pkg::*;

  localparam int RESET_CYCLES   = 6;
  localparam int RANDOM_WORDS   = 850;
  localparam int HOLDOFF_CYCLES = 300;
  // A walk visits at most every slot once, plus load and handoff cycles.
  localparam int DRAIN_CYCLES   = TOTAL_SLOTS + 16;
  // Quiet cycles allowed: hold-off plus a full walk, taken several times over.
  localparam int WATCHDOG_LIMIT = 4 * (HOLDOFF_CYCLES + DRAIN_CYCLES);

  // One response word as the table should produce it.
  typedef struct {
    logic [SLOT_W-1:0] slot;
    status_e           status;
  } grant_t;

  // -------------------------------------------------------------------------
  // Scoreboard: holds its own copy of the slot table, predicts the response
  // for each accepted request word and matches response words in order.
  // -------------------------------------------------------------------------
  class slot_ledger;
    logic [OWNER_W-1:0]    slot_owner [TOTAL_SLOTS];
    logic [LINK_W-1:0]     slot_link  [TOTAL_SLOTS];
    logic [POOL_CNT_W-1:0] pool_used;
    grant_t                expected_grants [$];
    int                    errors;

    function new();
      for (int i = 0; i < TOTAL_SLOTS; i++) begin
        slot_owner[i] = '0;
        slot_link[i]  = '0;
      end
      pool_used = '0;
      errors    = 0;
    endfunction

    function logic [SLOT_W-1:0] owner_home(logic [OWNER_W-1:0] id);
      logic [OWNER_W-1:0] h;
      h = id;
      if (id > HASH_LIMIT) h = (id >> HASH_SHIFT_A) ^ (id >> HASH_SHIFT_B);
      return SLOT_W'(h % HOME_SLOTS);
    endfunction

    // Step to the next slot of the chain; a null or out-of-range link ends it.
    function bit follow(logic [SLOT_W-1:0] s, output logic [SLOT_W-1:0] nxt);
      nxt = '0;
      if (slot_link[s] == '0 || slot_link[s] > TOTAL_SLOTS) return 1'b0;
      nxt = SLOT_W'(slot_link[s] - 1);
      return 1'b1;
    endfunction

    function grant_t walk_chain(logic op, logic [OWNER_W-1:0] id);
      grant_t            g;
      logic [SLOT_W-1:0] cur;
      logic [SLOT_W-1:0] nxt;
      logic [SLOT_W-1:0] free_slot;
      bit                have_free;
      cur       = owner_home(id);
      free_slot = '0;
      have_free = 1'b0;
      if (op == OP_RELEASE) begin
        for (int n = 0; n < TOTAL_SLOTS; n++) begin
          if (slot_owner[cur] == id) begin
            slot_owner[cur] = '0;
            g.slot   = cur;
            g.status = STAT_RELEASED;
            return g;
          end
          if (!follow(cur, nxt)) break;
          cur = nxt;
        end
        g.slot   = '0;
        g.status = STAT_NOT_FOUND;
        return g;
      end
      for (int n = 0; n < TOTAL_SLOTS; n++) begin
        if (slot_owner[cur] == id) begin
          g.slot   = cur;
          g.status = STAT_HIT;
          return g;
        end
        if (slot_owner[cur] == '0 && !have_free) begin
          have_free = 1'b1;
          free_slot = cur;
        end
        if (!follow(cur, nxt)) break;
        cur = nxt;
      end
      if (have_free) begin
        slot_owner[free_slot] = id;
        g.slot   = free_slot;
        g.status = STAT_CLAIMED;
      end else if (pool_used < POOL_SLOTS) begin
        // Append the next pool slot at the tail of the chain.
        g.slot          = SLOT_W'(HOME_SLOTS + pool_used);
        g.status        = STAT_APPENDED;
        pool_used       = pool_used + 1'b1;
        slot_owner[g.slot] = id;
        slot_link[g.slot]  = '0;
        slot_link[cur]     = LINK_W'(g.slot + 1);
      end else begin
        g.slot   = '0;
        g.status = STAT_POOL_FULL;
      end
      return g;
    endfunction

    function void note_request(logic op, logic [OWNER_W-1:0] id);
      expected_grants.push_back(walk_chain(op, id));
    endfunction

    task report_mismatch(string what);
      errors++;
      $display("tb: mismatch at %0t: %s", $realtime, what);
    endtask

    task check_response(logic [SLOT_W-1:0] slot, logic [STATUS_W-1:0] status);
      grant_t g;
      if (expected_grants.size() == 0) begin
        report_mismatch($sformatf("unexpected response slot %0d status %0d", slot, status));
        return;
      end
      g = expected_grants.pop_front();
      if (slot !== g.slot)
        report_mismatch($sformatf("slot %0d, want %0d (%s)", slot, g.slot, g.status.name()));
      if (status !== g.status)
        report_mismatch($sformatf("status %0d, want %s", status, g.status.name()));
    endtask

    function int pending();
      return expected_grants.size();
    endfunction
  endclass

  // -------------------------------------------------------------------------
  // Clock, reset, channels and the block
  // -------------------------------------------------------------------------
  logic clk_i;
  logic rst_ni;

  hosa_req_if req ();
  hosa_rsp_if rsp ();

  hashed_owner_slot_allocator dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  slot_ledger ledger;

  // Shared pacing flags: steady turns idling off on both sides; hold_rsp asks
  // the receiver for one long hold-off.
  bit steady;
  bit hold_rsp;

  // Large hashed ids that come back again and again, so that they hit and
  // get released instead of only being claimed once.
  logic [OWNER_W-1:0] repeat_ids [16];

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // -------------------------------------------------------------------------
  // Request side
  // -------------------------------------------------------------------------

  // Offer one word and hold it until the block takes it. Idle first at
  // random; valid is only lowered when a gap really follows, so it is never
  // dropped and raised within one step.
  task automatic send_word(input logic op, input logic [OWNER_W-1:0] id);
    if (!steady && $urandom_range(99) < 18) begin
      req.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 18);
    end
    req.valid    <= 1'b1;
    req.op       <= op;
    req.owner_id <= id;
    do @(posedge clk_i); while (req.ready !== 1'b1);
    ledger.note_request(op, id);
  endtask

  // Short, hand-picked sequence: free-slot matching on id zero, hits,
  // pool appends, reclaiming a freed pool slot, the hash boundary at 0x1000,
  // the extreme ids and a release that finds nothing.
  task automatic run_directed();
    send_word(OP_ACQUIRE, 64'd0);                   // zero hits a free home
    send_word(OP_RELEASE, 64'd0);                   // zero frees a free slot
    send_word(OP_ACQUIRE, 64'd5);                   // claim home 5
    send_word(OP_ACQUIRE, 64'd5);                   // hit
    send_word(OP_ACQUIRE, 64'd69);                  // append pool slot
    send_word(OP_ACQUIRE, 64'd133);                 // append behind it
    send_word(OP_RELEASE, 64'd69);                  // free a pool slot
    send_word(OP_ACQUIRE, 64'd197);                 // reclaim the freed pool slot
    send_word(OP_ACQUIRE, 64'd133);                 // hit deep in the chain
    send_word(OP_RELEASE, 64'd12345);               // not found
    send_word(OP_ACQUIRE, 64'h1000);                // last unhashed id, home 0
    send_word(OP_ACQUIRE, 64'h1001);                // first hashed id
    send_word(OP_ACQUIRE, '1);                      // all ones
    send_word(OP_ACQUIRE, 64'h8000_0000_0000_0000); // top bit only
    send_word(OP_ACQUIRE, 64'd0);                   // home 0 taken: zero appends
    send_word(OP_RELEASE, '1);
    send_word(OP_RELEASE, 64'h1001);
    send_word(OP_RELEASE, 64'd5);
    send_word(OP_RELEASE, 64'd5);                   // second release misses
    send_word(OP_ACQUIRE, 64'hAAAA_AAAA_5555_5555);
    send_word(OP_RELEASE, 64'hAAAA_AAAA_5555_5555);
  endtask

  // Pick an owner id. Most ids crowd onto three home slots so that chains
  // grow, the pool runs dry and freed slots get reclaimed; the rest are
  // repeated large ids, fresh random ids, zero and ids around 0x1000.
  function automatic logic [OWNER_W-1:0] pick_owner();
    int roll;
    int homes [3];
    homes = '{3, 9, 40};
    roll  = $urandom_range(99);
    if (roll < 55) return OWNER_W'($urandom_range(63) * HOME_SLOTS + homes[$urandom_range(2)]);
    if (roll < 70) return repeat_ids[$urandom_range(15)];
    if (roll < 88) return {$urandom, $urandom};
    if (roll < 93) return '0;
    return OWNER_W'($urandom_range(32'h1001, 32'hFC0));
  endfunction

  task automatic run_random();
    logic op;
    for (int i = 0; i < 16; i++) repeat_ids[i] = {$urandom, $urandom} | 64'h1_0000;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      // Stall the receiver once while words keep coming, so the block backs up.
      if (n == 150) hold_rsp = 1'b1;
      steady = (n >= 300 && n < 450);
      op = ($urandom_range(99) < 40) ? OP_RELEASE : OP_ACQUIRE;
      send_word(op, pick_owner());
    end
    steady = 1'b0;
  endtask

  initial begin : main
    ledger       = new();
    steady       = 1'b0;
    hold_rsp     = 1'b0;
    rst_ni       <= 1'b0;
    req.valid    <= 1'b0;
    req.op       <= OP_ACQUIRE;
    req.owner_id <= '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    run_random();
    req.valid <= 1'b0;

    // Drain: wait for every response, then give stray words time to show.
    while (ledger.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (ledger.errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  // -------------------------------------------------------------------------
  // Response side: check each accepted word, then pick ready for the next
  // edge. The hold-off is counted here, independent of the request side.
  // -------------------------------------------------------------------------
  initial begin : rsp_side
    int holdoff;
    holdoff   = 0;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
        ledger.check_response(rsp.slot_index, rsp.status);
      end
      if (hold_rsp) begin
        hold_rsp = 1'b0;
        holdoff  = HOLDOFF_CYCLES;
      end
      if (holdoff > 0) begin
        holdoff--;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= steady || ($urandom_range(99) >= 18);
      end
    end
  end

  // -------------------------------------------------------------------------
  // Watchdog: count edges where neither channel moves a word; give up when
  // the count reaches the limit.
  // -------------------------------------------------------------------------
  initial begin : watchdog
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((req.valid === 1'b1 && req.ready === 1'b1) ||
          (rsp.valid === 1'b1 && rsp.ready === 1'b1)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("tb: timeout after %0d quiet cycles", quiet);
        $display("tb: done, errors");
        $finish;
      end
    end
  end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/hosa_pkg.sv
hw/rtl/hosa_req_if.sv
hw/rtl/hosa_rsp_if.sv
hw/rtl/hosa_slot_store.sv
hw/rtl/hosa_walker.sv
hw/rtl/hashed_owner_slot_allocator.sv
sim/tb.sv
